[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros used by the tracker lane rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/dadt_pkg.sv]
// ----------------------------------------------------------------------------
// dadt_pkg
// types and constants of the dual axis dead band step tracker
// ----------------------------------------------------------------------------
package dadt_pkg;

  localparam int POS_W     = 15;
  localparam int ERR_W     = 16;
  localparam int ANGLE_W   = 7;
  localparam int DUTY_HI_W = 8;
  localparam int DUTY_LO_W = 2;
  localparam int NUM_W     = POS_W + ANGLE_W;
  localparam int CNT_W     = $clog2(ANGLE_W);
  localparam int CFG_IDX_W = 3;

  localparam logic [ANGLE_W-1:0] ANGLE_FULL = ANGLE_W'(120);

  localparam logic [POS_W-1:0] HOME_X = POS_W'(1500);
  localparam logic [POS_W-1:0] HOME_Y = POS_W'(1500);

  localparam logic [POS_W-1:0] RST_DEADZONE = POS_W'(10);
  localparam logic [POS_W-1:0] RST_STEP     = POS_W'(32);
  localparam logic [POS_W-1:0] RST_MIN      = POS_W'(500);
  localparam logic [POS_W-1:0] RST_MAX      = POS_W'(2500);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE  = 3'd0,
    REG_PAN_STEP  = 3'd1,
    REG_TILT_STEP = 3'd2,
    REG_PAN_MIN   = 3'd3,
    REG_PAN_MAX   = 3'd4,
    REG_TILT_MIN  = 3'd5,
    REG_TILT_MAX  = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LANE_IDLE,
    LANE_PREP,
    LANE_DIV,
    LANE_DONE
  } lane_state_t;

  typedef struct packed {
    logic                    start;
    logic signed [ERR_W-1:0] err;
    logic [POS_W-1:0]        band;
    logic [POS_W-1:0]        step;
    logic [POS_W-1:0]        lo;
    logic [POS_W-1:0]        hi;
  } lane_cmd_t;

  typedef struct packed {
    logic                 done;
    logic [ANGLE_W-1:0]   angle;
    logic [DUTY_HI_W-1:0] duty_high;
    logic [DUTY_LO_W-1:0] duty_low;
  } lane_result_t;

endpackage

[hdl/dadt_channels.sv]
// ----------------------------------------------------------------------------
// dadt channel interfaces
// valid/ready channels for sensor words and result words
// ----------------------------------------------------------------------------
interface dadt_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pan_error;
  logic signed [15:0] tilt_error;

  modport source (output valid, output pan_error, output tilt_error, input ready);
  modport sink (input valid, input pan_error, input tilt_error, output ready);
endinterface

interface dadt_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] pan_deg;
  logic [6:0] tilt_deg;
  logic [7:0] pan_duty_high;
  logic [1:0] pan_duty_low;
  logic [7:0] tilt_duty_high;
  logic [1:0] tilt_duty_low;

  modport source (
    output valid, output pan_deg, output tilt_deg,
    output pan_duty_high, output pan_duty_low,
    output tilt_duty_high, output tilt_duty_low,
    input ready
  );
  modport sink (
    input valid, input pan_deg, input tilt_deg,
    input pan_duty_high, input pan_duty_low,
    input tilt_duty_high, input tilt_duty_low,
    output ready
  );
endinterface

[hdl/dadt_axis_lane.sv]
// ----------------------------------------------------------------------------
// dadt_axis_lane
// one axis: dead band step, clamp, and angle scaling by a restoring divider
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dadt_axis_lane import dadt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [POS_W-1:0]   home,
  input  lane_cmd_t          cmd,
  input  logic               ack,
  output logic               idle,
  output lane_result_t       res
);

  lane_state_t state, state_next;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] lo_q;
  logic [POS_W-1:0] hi_q;
  logic [NUM_W-1:0] rem;
  logic [POS_W-1:0] den;
  logic [ANGLE_W-1:0] quot;
  logic [CNT_W-1:0] cnt;

  // step and clamp, one bit of headroom each side
  logic signed [POS_W+1:0] pos_s, step_s, lo_s, hi_s, band_s, err_s, stepped;
  logic                    up, down;
  logic [POS_W-1:0]        clamped, pos_next;

  always_comb begin
    pos_s   = signed'({2'b00, pos});
    step_s  = signed'({2'b00, cmd.step});
    lo_s    = signed'({2'b00, cmd.lo});
    hi_s    = signed'({2'b00, cmd.hi});
    band_s  = signed'({2'b00, cmd.band});
    err_s   = signed'({cmd.err[ERR_W-1], cmd.err});
    up      = err_s > band_s;
    down    = err_s < -band_s;
    stepped = up ? (pos_s + step_s) : (pos_s - step_s);
    priority if (stepped < lo_s) begin
      clamped = cmd.lo;
    end else if (stepped > hi_s) begin
      clamped = cmd.hi;
    end else begin
      clamped = stepped[POS_W-1:0];
    end
    pos_next = (up || down) ? clamped : pos;
  end

  // scaling setup
  logic [POS_W-1:0] offset;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] den_shift;
  logic             fits;

  always_comb begin
    offset    = pos - lo_q;
    num       = NUM_W'(offset) * NUM_W'(ANGLE_FULL);
    den_shift = NUM_W'(den) << cnt;
    fits      = rem >= den_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LANE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    idle       = 1'b0;
    res        = '0;
    unique case (state)
      LANE_IDLE: begin
        idle = 1'b1;
        if (cmd.start) begin
          state_next = LANE_PREP;
        end
      end
      LANE_PREP: begin
        priority if ((hi_q <= lo_q) || (pos <= lo_q) || (pos >= hi_q)) begin
          state_next = LANE_DONE;
        end else begin
          state_next = LANE_DIV;
        end
      end
      LANE_DIV: begin
        if (cnt == '0) begin
          state_next = LANE_DONE;
        end
      end
      LANE_DONE: begin
        res.done = 1'b1;
        if (ack) begin
          state_next = LANE_IDLE;
        end
      end
      default: state_next = LANE_IDLE;
    endcase
    res.angle     = quot;
    res.duty_high = pos[POS_W-1 -: DUTY_HI_W];
    res.duty_low  = pos[POS_W-1-DUTY_HI_W -: DUTY_LO_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= home;
    end else if (state == LANE_IDLE && cmd.start) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      LANE_IDLE: begin
        if (cmd.start) begin
          lo_q <= cmd.lo;
          hi_q <= cmd.hi;
        end
      end
      LANE_PREP: begin
        rem <= num;
        den <= hi_q - lo_q;
        cnt <= CNT_W'(ANGLE_W - 1);
        priority if ((hi_q <= lo_q) || (pos <= lo_q)) begin
          quot <= '0;
        end else if (pos >= hi_q) begin
          quot <= ANGLE_FULL;
        end else begin
          quot <= '0;
        end
      end
      LANE_DIV: begin
        if (fits) begin
          rem <= rem - den_shift;
        end
        quot <= {quot[ANGLE_W-2:0], fits};
        cnt  <= cnt - CNT_W'(1);
      end
      LANE_DONE: begin
      end
      default: begin
      end
    endcase
  end

  `ASSERT_IMP(a_start_when_idle, cmd.start, state == LANE_IDLE, "lane started while busy")
  `ASSERT_IMP(a_angle_range, state == LANE_DONE, quot <= ANGLE_FULL, "angle above full scale")
  `ASSERT_NXT(a_pos_hold, state != LANE_IDLE, $stable(pos), "position moved mid item")

endmodule

[hdl/dadt_merge.sv]
// ----------------------------------------------------------------------------
// dadt_merge
// joins both lane results into the registered result word
// ----------------------------------------------------------------------------
module dadt_merge import dadt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  lane_result_t      pan_res,
  input  lane_result_t      tilt_res,
  output logic              ack,
  dadt_out_if.source        result
);

  // load when both lanes are done and the output slot frees up
  assign ack = pan_res.done && tilt_res.done && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ack) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      result.pan_deg        <= pan_res.angle;
      result.tilt_deg       <= tilt_res.angle;
      result.pan_duty_high  <= pan_res.duty_high;
      result.pan_duty_low   <= pan_res.duty_low;
      result.tilt_duty_high <= tilt_res.duty_high;
      result.tilt_duty_low  <= tilt_res.duty_low;
    end
  end

endmodule

[hdl/dual_axis_deadband_step_tracker_top.sv]
// ----------------------------------------------------------------------------
// dual_axis_deadband_step_tracker_top
// pan and tilt lanes stepping servo positions, with merged angle/duty output
// ----------------------------------------------------------------------------
// flow: a taken sensor word runs through the lane states prep, div (the
//   7-iteration restoring divider) and done, then into the registered result
//   word; div is skipped when the angle is fixed by the limits (at or beyond
//   min/max, empty span); a new word is taken only when both lanes are idle
// reset: registers return to defaults, both positions go home, output empty
module dual_axis_deadband_step_tracker_top import dadt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data,
  dadt_in_if.sink              sensor,
  dadt_out_if.source           result
);

  logic [POS_W-1:0] deadzone, pan_step, tilt_step;
  logic [POS_W-1:0] pan_min, pan_max, tilt_min, tilt_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone  <= RST_DEADZONE;
      pan_step  <= RST_STEP;
      tilt_step <= RST_STEP;
      pan_min   <= RST_MIN;
      pan_max   <= RST_MAX;
      tilt_min  <= RST_MIN;
      tilt_max  <= RST_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEADZONE:  deadzone  <= cfg_data;
        REG_PAN_STEP:  pan_step  <= cfg_data;
        REG_TILT_STEP: tilt_step <= cfg_data;
        REG_PAN_MIN:   pan_min   <= cfg_data;
        REG_PAN_MAX:   pan_max   <= cfg_data;
        REG_TILT_MIN:  tilt_min  <= cfg_data;
        REG_TILT_MAX:  tilt_max  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  logic         pan_idle, tilt_idle, ack, take;
  lane_cmd_t    pan_cmd, tilt_cmd;
  lane_result_t pan_res, tilt_res;

  assign sensor.ready = pan_idle && tilt_idle;
  assign take         = sensor.valid && sensor.ready;

  always_comb begin
    pan_cmd.start  = take;
    pan_cmd.err    = sensor.pan_error;
    pan_cmd.band   = deadzone;
    pan_cmd.step   = pan_step;
    pan_cmd.lo     = pan_min;
    pan_cmd.hi     = pan_max;
    tilt_cmd.start = take;
    tilt_cmd.err   = sensor.tilt_error;
    tilt_cmd.band  = deadzone;
    tilt_cmd.step  = tilt_step;
    tilt_cmd.lo    = tilt_min;
    tilt_cmd.hi    = tilt_max;
  end

  dadt_axis_lane u_pan (
    .clk  (clk),
    .rst  (rst),
    .home (HOME_X),
    .cmd  (pan_cmd),
    .ack  (ack),
    .idle (pan_idle),
    .res  (pan_res)
  );

  dadt_axis_lane u_tilt (
    .clk  (clk),
    .rst  (rst),
    .home (HOME_Y),
    .cmd  (tilt_cmd),
    .ack  (ack),
    .idle (tilt_idle),
    .res  (tilt_res)
  );

  dadt_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .pan_res  (pan_res),
    .tilt_res (tilt_res),
    .ack      (ack),
    .result   (result)
  );

endmodule
